// File: design/order_book_state_hash_defines.svh
// Assertion macros shared by the order book state hash checkers.
`ifndef ORDER_BOOK_STATE_HASH_DEFINES_SVH
`define ORDER_BOOK_STATE_HASH_DEFINES_SVH

// Clocked assertion with an active-low disable; pass 1'b1 to keep it always armed.
`define OBSH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Signal holds its value while a word is offered but not taken.
`define OBSH_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
  `OBSH_ASSERT(lbl, clk, rst_n, (vld) && !(rdy) |=> $stable(sig), msg)

`endif

// File: design/obsh_pkg.sv
// Types, constants and hash step function for the order book state hash.
`default_nettype none

package obsh_pkg;

  localparam int unsigned HashW   = 64;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned JobW    = 160;
  localparam int unsigned CntW    = 5;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = 1;
  localparam int unsigned QCntW   = 2;

  localparam logic [HashW-1:0] OffsetBasis = 64'hCBF2_9CE4_8422_2325;

  localparam logic [1:0] CmdHeader = 2'd0;
  localparam logic [1:0] CmdCount  = 2'd1;
  localparam logic [1:0] CmdLevel  = 2'd2;

  localparam logic [CntW-1:0] HeaderBytes = 5'd16;
  localparam logic [CntW-1:0] CountBytes  = 5'd4;
  localparam logic [CntW-1:0] LevelBytes  = 5'd20;

  // One classified item: bytes to absorb, least significant first.
  typedef struct packed {
    logic [JobW-1:0] data;
    logic [CntW-1:0] nbytes;
    logic            restart;
    logic            last;
  } obsh_job_t;

  // Multiply by the FNV prime 2^40 + 0x1B3, modulo 2^64, as shifts and adds.
  function automatic logic [HashW-1:0] fnv_mul(input logic [HashW-1:0] h);
    fnv_mul = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
  endfunction

endpackage

`default_nettype wire

// File: design/obsh_in_if.sv
// Input channel: one order book item per word.
`default_nettype none

interface obsh_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [63:0]        sequence_req;
  logic [63:0]        trade_ref;
  logic [31:0]        level_count;
  logic signed [63:0] price;
  logic [63:0]        quantity;
  logic [31:0]        num_orders;
  logic               last;

  modport source (
    output valid, command, sequence_req, trade_ref, level_count, price, quantity,
           num_orders, last,
    input  ready
  );
  modport sink (
    input  valid, command, sequence_req, trade_ref, level_count, price, quantity,
           num_orders, last,
    output ready
  );
endinterface

`default_nettype wire

// File: design/obsh_out_if.sv
// Output channel: one state hash per word.
`default_nettype none

interface obsh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] state_hash;

  modport source (output valid, state_hash, input ready);
  modport sink (input valid, state_hash, output ready);
endinterface

`default_nettype wire

// File: design/obsh_front.sv
// Front end: accepts items and turns them into byte jobs for the queue.
`default_nettype none

module obsh_front (
  obsh_in_if.sink              in_i,
  output obsh_pkg::obsh_job_t  job_o,
  output logic                 job_valid_o,
  input  logic                 job_ready_i
);

  obsh_pkg::obsh_job_t job;

  always_comb begin
    job         = '0;
    job.last    = in_i.last;
    case (in_i.command)
      obsh_pkg::CmdHeader: begin
        job.data    = {32'd0, in_i.trade_ref, in_i.sequence_req};
        job.nbytes  = obsh_pkg::HeaderBytes;
        job.restart = 1'b1;
      end
      obsh_pkg::CmdCount: begin
        job.data    = {128'd0, in_i.level_count};
        job.nbytes  = obsh_pkg::CountBytes;
      end
      obsh_pkg::CmdLevel: begin
        job.data    = {in_i.num_orders, in_i.quantity, $unsigned(in_i.price)};
        job.nbytes  = obsh_pkg::LevelBytes;
      end
      default: begin
        // undefined command: nothing absorbed, last mark still reports
        job.nbytes  = '0;
      end
    endcase
  end

  assign job_o       = job;
  assign job_valid_o = in_i.valid;
  assign in_i.ready  = job_ready_i;

endmodule

`default_nettype wire

// File: design/obsh_fifo.sv
// Two-entry job queue between front and back.
`default_nettype none

module obsh_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  obsh_pkg::obsh_job_t  push_job_i,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  output obsh_pkg::obsh_job_t  pop_job_o,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i
);

  obsh_pkg::obsh_job_t                entry_q [obsh_pkg::QDepth];
  logic [obsh_pkg::QPtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [obsh_pkg::QPtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [obsh_pkg::QCntW-1:0]         count_q, count_d;
  logic                               push, pop;

  assign push_ready_o = (count_q != obsh_pkg::QCntW'(obsh_pkg::QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_job_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

// File: design/obsh_back.sv
// Back end: byte-serial FNV-1a absorb and the result output register.
`default_nettype none

module obsh_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  obsh_pkg::obsh_job_t  job_i,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  obsh_out_if.source           out_o
);

  logic                             busy_q, busy_d;
  logic [obsh_pkg::JobW-1:0]        data_q, data_d;
  logic [obsh_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic                             last_q, last_d;
  logic [obsh_pkg::HashW-1:0]       hash_q, hash_d;
  logic                             out_valid_q, out_valid_d;
  logic [obsh_pkg::HashW-1:0]       out_hash_q, out_hash_d;

  logic                             out_free, stall, step, fin, emit_fin;
  logic                             job_empty_last, load, emit_zero;
  logic [obsh_pkg::HashW-1:0]       hash_step, hash_cur, hash_base;

  assign out_free  = !out_valid_q || out_o.ready;
  assign stall     = (cnt_q == obsh_pkg::CntW'(1)) && last_q && !out_free;
  assign step      = busy_q && !stall;
  assign fin       = step && (cnt_q == obsh_pkg::CntW'(1));
  assign emit_fin  = fin && last_q;
  assign hash_step = obsh_pkg::fnv_mul(hash_q ^ {56'd0, data_q[obsh_pkg::ByteW-1:0]});
  assign hash_cur  = step ? hash_step : hash_q;
  assign hash_base = job_i.restart ? obsh_pkg::OffsetBasis : hash_cur;

  assign job_empty_last = job_i.last && (job_i.nbytes == '0);
  assign job_ready_o    = (!busy_q || fin) && (!job_empty_last || (out_free && !emit_fin));
  assign load           = job_valid_i && job_ready_o;
  assign emit_zero      = load && job_empty_last;

  always_comb begin
    busy_d = busy_q;
    data_d = data_q;
    cnt_d  = cnt_q;
    last_d = last_q;
    hash_d = hash_q;
    if (load) begin
      hash_d = hash_base;
      data_d = job_i.data;
      cnt_d  = job_i.nbytes;
      last_d = job_i.last;
      busy_d = (job_i.nbytes != '0);
    end else if (step) begin
      hash_d = hash_step;
      data_d = data_q >> obsh_pkg::ByteW;
      cnt_d  = cnt_q - 1'b1;
      busy_d = !fin;
    end

    out_valid_d = out_valid_q;
    out_hash_d  = out_hash_q;
    if (emit_fin) begin
      out_valid_d = 1'b1;
      out_hash_d  = hash_step;
    end else if (emit_zero) begin
      out_valid_d = 1'b1;
      out_hash_d  = hash_base;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      hash_q      <= obsh_pkg::OffsetBasis;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      hash_q      <= hash_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    out_hash_q <= out_hash_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.state_hash = out_hash_q;

endmodule

`default_nettype wire

// File: design/order_book_state_hash.sv
// Top level of the order book state hash: front, job queue, back.
//
//   channel   dir   word                                     handshake
//   in_i      in    command, sequence_req ... num_orders,    valid/ready
//                   last
//   out_o     out   state_hash                               valid/ready
//
// Unless stalled, the back absorbs one byte per cycle through the xor-multiply on the
// running hash: header 16 bytes, count item 4, level item 20, undefined command none.
// A queued job loads in the cycle the last one finishes, unless both report and it has no bytes.
// A two-entry queue lets the front keep taking items while the back works.
// Reset sets the hash to the offset basis and empties queue and output.
// A held result stalls the last byte of the next reporting item, or its load if it has none.
`default_nettype none

module order_book_state_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  obsh_in_if.sink     in_i,
  obsh_out_if.source  out_o
);

  obsh_pkg::obsh_job_t front_job, back_job;
  logic                front_valid, front_ready;
  logic                back_valid, back_ready;

  obsh_front u_front (
    .in_i        (in_i),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  obsh_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_job_i   (front_job),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_job_o    (back_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  obsh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (back_job),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// File: design/obsh_checker.sv
// Port-level checks for the order book state hash, bound to the top level.
`default_nettype none
`include "order_book_state_hash_defines.svh"

module obsh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_state_hash_i
);

  // reporting items taken but not yet delivered
  logic [2:0] pending_q, pending_d;
  logic       in_take, out_take;

  assign in_take  = in_valid_i && in_ready_i && in_last_i;
  assign out_take = out_valid_i && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_take && !out_take) begin
      pending_d = pending_q + 1'b1;
    end else if (out_take && !in_take) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `OBSH_HOLD(a_out_valid_hold, clk_i, rst_ni, out_valid_i, out_ready_i, out_valid_i, "valid dropped")
  `OBSH_HOLD(a_out_hash_hold, clk_i, rst_ni, out_valid_i, out_ready_i, out_state_hash_i, "hash moved")
  `OBSH_ASSERT(a_no_spurious, clk_i, rst_ni, out_valid_i |-> pending_q != 3'd0, "spurious result")
  `OBSH_ASSERT(a_reset_idle, clk_i, 1'b1, !rst_ni |=> !out_valid_i, "result valid in reset")

endmodule

bind order_book_state_hash obsh_checker u_obsh_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_last_i        (in_i.last),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_state_hash_i (out_o.state_hash)
);

`default_nettype wire

// File: tb/tb_order_book_state_hash.sv
// Self-checking testbench for the order book state hash: directed and random books, FNV-1a model.
`default_nettype none

module tb_order_book_state_hash;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  CmdUnused = 2'd3;
  localparam logic [63:0] FnvBasis  = 64'd14695981039346656037;
  localparam logic [63:0] FnvPrime  = 64'd1099511628211;

  typedef struct {
    logic [1:0]         cmd;
    logic [63:0]        seq;
    logic [63:0]        tid;
    logic [31:0]        lvl_cnt;
    logic signed [63:0] price;
    logic [63:0]        qty;
    logic [31:0]        ord_cnt;
    logic               last;
  } book_word_t;

  logic clk_i;
  logic rst_ni;

  obsh_in_if  book_in ();
  obsh_out_if hash_out ();

  order_book_state_hash u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (book_in),
    .out_o  (hash_out)
  );

  logic [63:0] book_hash;
  logic [63:0] hash_q[$];
  logic [63:0] want_hash;
  int          tx_idle_pct = 37;
  int          rx_idle_pct = 37;
  int          rx_hold_left = 0;
  int          words_sent = 0;
  int          hashes_seen = 0;
  int          errors = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // FNV-1a over the low nbytes of a word, least significant byte first
  function automatic void absorb_bytes(input logic [63:0] data, input int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      book_hash = book_hash ^ {56'd0, data[8*i +: 8]};
      book_hash = book_hash * FnvPrime;
    end
  endfunction

  function automatic void predict_word(input book_word_t w);
    case (w.cmd)
      obsh_pkg::CmdHeader: begin
        book_hash = FnvBasis;
        absorb_bytes(w.seq, 8);
        absorb_bytes(w.tid, 8);
      end
      obsh_pkg::CmdCount: begin
        absorb_bytes({32'd0, w.lvl_cnt}, 4);
      end
      obsh_pkg::CmdLevel: begin
        absorb_bytes(w.price, 8);
        absorb_bytes(w.qty, 8);
        absorb_bytes({32'd0, w.ord_cnt}, 4);
      end
      default: ;
    endcase
    if (w.last) hash_q = {hash_q, book_hash};
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, 63'd0};
      3:       return {1'b0, {63{1'b1}}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] rand32();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // all fields random, unused ones included
  function automatic book_word_t random_word(input logic [1:0] cmd);
    book_word_t w;
    w.cmd     = cmd;
    w.seq     = rand64();
    w.tid     = rand64();
    w.lvl_cnt = rand32();
    w.price   = rand64();
    w.qty     = rand64();
    w.ord_cnt = rand32();
    w.last    = 1'($urandom_range(1));
    return w;
  endfunction

  task automatic send_word(input book_word_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      book_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    book_in.command      <= w.cmd;
    book_in.sequence_req <= w.seq;
    book_in.trade_ref    <= w.tid;
    book_in.level_count  <= w.lvl_cnt;
    book_in.price        <= w.price;
    book_in.quantity     <= w.qty;
    book_in.num_orders   <= w.ord_cnt;
    book_in.last         <= w.last;
    book_in.valid        <= 1'b1;
    do @(posedge clk_i); while (!book_in.ready);
    predict_word(w);
    words_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    book_in.valid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk_i);
  endtask

  // header, then two sides of count plus levels; sometimes cut short
  task automatic send_book();
    book_word_t w;
    int         nlev;
    w = random_word(obsh_pkg::CmdHeader);
    w.last = ($urandom_range(9) == 0);
    send_word(w);
    for (int side = 0; side < 2; side++) begin
      nlev = $urandom_range(5);
      w = random_word(obsh_pkg::CmdCount);
      if ($urandom_range(7) != 0) w.lvl_cnt = 32'(nlev);
      w.last = (side == 1 && nlev == 0) || ($urandom_range(19) == 0);
      send_word(w);
      for (int j = 0; j < nlev; j++) begin
        if ($urandom_range(39) == 0) return;
        w = random_word(obsh_pkg::CmdLevel);
        w.last = (side == 1 && j == nlev - 1) || ($urandom_range(19) == 0);
        send_word(w);
      end
    end
  endtask

  task automatic test_directed();
    book_word_t w;
    // hash from the reset basis, before any header
    w = random_word(obsh_pkg::CmdCount);
    w.lvl_cnt = 32'h1234_5678; w.last = 1'b1; send_word(w);
    w = random_word(CmdUnused); w.last = 1'b1; send_word(w);
    w = random_word(obsh_pkg::CmdHeader);
    w.seq = '0; w.tid = '0; w.last = 1'b1; send_word(w);
    w = random_word(obsh_pkg::CmdHeader);
    w.seq = '1; w.tid = '1; w.last = 1'b0; send_word(w);
    w = random_word(obsh_pkg::CmdCount);  w.lvl_cnt = '0; w.last = 1'b0; send_word(w);
    w = random_word(obsh_pkg::CmdCount);  w.lvl_cnt = '1; w.last = 1'b1; send_word(w);
    w = random_word(obsh_pkg::CmdLevel);
    w.price = {1'b1, 63'd0}; w.qty = '0; w.ord_cnt = '0; w.last = 1'b1;
    send_word(w);
    w = random_word(obsh_pkg::CmdLevel);
    w.price = {1'b0, {63{1'b1}}}; w.qty = '1; w.ord_cnt = '1; w.last = 1'b1;
    send_word(w);
    w = random_word(obsh_pkg::CmdLevel);
    w.price = -64'sd1; w.qty = 64'd1; w.ord_cnt = 32'd1; w.last = 1'b0;
    send_word(w);
    w = random_word(obsh_pkg::CmdLevel);  w.price = '0; w.last = 1'b1; send_word(w);
    w = random_word(CmdUnused); w.last = 1'b0; send_word(w);
    w = random_word(CmdUnused); w.last = 1'b1; send_word(w);
    w = random_word(obsh_pkg::CmdHeader);
    w.seq = {1'b1, 63'd0}; w.tid = 64'h0123_4567_89AB_CDEF; w.last = 1'b0;
    send_word(w);
    w = random_word(obsh_pkg::CmdCount);  w.lvl_cnt = 32'd2; w.last = 1'b1; send_word(w);
    w = random_word(obsh_pkg::CmdLevel);  w.last = 1'b1; send_word(w);
    w = random_word(obsh_pkg::CmdLevel);  w.last = 1'b1; send_word(w);
    w = random_word(obsh_pkg::CmdHeader); w.last = 1'b1; send_word(w);
  endtask

  task automatic test_random_books(input int target);
    book_word_t w;
    while (words_sent < target) begin
      if ($urandom_range(99) < 12) begin
        w = random_word(2'($urandom_range(3)));
        send_word(w);
      end else begin
        send_book();
      end
    end
  endtask

  // receiver holds off while a run of reporting level words arrives, so the input must stall
  task automatic test_backpressure();
    book_word_t w;
    tx_idle_pct = 0;
    rx_hold_left = 400;
    for (int i = 0; i < 40; i++) begin
      w = random_word(obsh_pkg::CmdLevel);
      w.last = 1'b1;
      send_word(w);
    end
    tx_idle_pct = 37;
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 4; i++) begin
      send_book();
      wait_drain();
    end
  endtask

  task automatic test_full_rate(input int count);
    int stop_at;
    stop_at = words_sent + count;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    while (words_sent < stop_at) send_book();
    tx_idle_pct = 37;
    rx_idle_pct = 37;
  endtask

  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      hash_out.ready <= 1'b0;
    end else begin
      hash_out.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && hash_out.valid && hash_out.ready) begin
      hashes_seen++;
      if (hash_q.size() == 0) begin
        $display("%0t: unexpected hash word, expected none, actual %h",
                 $time, hash_out.state_hash);
        errors++;
      end else begin
        want_hash = hash_q.pop_front();
        if (hash_out.state_hash !== want_hash) begin
          $display("%0t: state_hash mismatch, expected %h, actual %h",
                   $time, want_hash, hash_out.state_hash);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_ni               = 1'b0;
    book_in.valid        = 1'b0;
    book_in.command      = obsh_pkg::CmdHeader;
    book_in.sequence_req = '0;
    book_in.trade_ref    = '0;
    book_in.level_count  = '0;
    book_in.price        = '0;
    book_in.quantity     = '0;
    book_in.num_orders   = '0;
    book_in.last         = 1'b0;
    hash_out.ready       = 1'b0;
    book_hash            = FnvBasis;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_books(900);
    test_backpressure();
    test_drain_pause();
    test_full_rate(250);
    test_random_books(1900);

    wait_drain();
    repeat (64) @(posedge clk_i);

    $display("%0d words sent, %0d hashes checked, %0d mismatches",
             words_sent, hashes_seen, errors);
    $display("covered corner fields, unused command, pre-header hashing, random books, "
             , "output hold-off, drain pause and full rate");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
